/* hdl/cfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the checksummed frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int CHAN_W   = 3;
    localparam int WORD_W   = 32;
    localparam int WHOLE_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] TRAILER_RST = 8'h5A;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 6'd49;

    // parser phase
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_TAIL = 5'b10000
    } phase_t;

    // word sequencer state
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_LD   = 4'b0100,
        ST_CV   = 4'b1000
    } seq_state_t;

endpackage

/* hdl/cfp_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_channels
// Valid/ready stream interfaces for received bytes and decoded words.
// ----------------------------------------------------------------------------
interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  channel;
    logic [31:0] raw_word;
    logic [15:0] whole_value;
    logic        last;

    modport source (output valid, output channel, output raw_word, output whole_value,
                    output last, input ready);
    modport sink   (input valid, input channel, input raw_word, input whole_value,
                    input last, output ready);
endinterface

/* hdl/checksummed_frame_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_parser_top
// Header/length/checksum/trailer frame parser with binary32 word decode.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock cycle while the word sequencer is idle.
// After a good trailer the input is held off while WORD_COUNT words are
// decoded: each word takes four byte reads through the store's single read
// port, each a read step plus a load step, and then one conversion step in
// the shared shift unit; the conversion step waits while the result side
// stalls. The last result may still be waiting in the output register while
// the next frame's bytes are taken. The payload store reads as zero after
// reset through per-entry valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module checksummed_frame_parser_top
    import cfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int WORD_COUNT    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cfp_byte_if.sink              rx,
    cfp_result_if.source          result
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    logic          frame_start;
    logic          seq_busy;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic          st_re;
    logic [AW-1:0] st_raddr;
    logic [7:0]    st_rdata;

    cfp_rx_fsm #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_rx_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .busy      (seq_busy),
        .start     (frame_start),
        .st_we     (st_we),
        .st_waddr  (st_waddr),
        .st_wdata  (st_wdata)
    );

    cfp_store #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    cfp_word_seq #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .WORD_COUNT    (WORD_COUNT)
    ) u_word_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (frame_start),
        .busy     (seq_busy),
        .st_re    (st_re),
        .st_raddr (st_raddr),
        .st_rdata (st_rdata),
        .result   (result)
    );

endmodule

/* hdl/cfp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/cfp_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_store
// Payload byte store: RAM plus per-entry valid bits so unwritten bytes read 0.
// ----------------------------------------------------------------------------
module cfp_store #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [$clog2(PAYLOAD_DEPTH)-1:0] waddr,
    input  logic [7:0]                       wdata,
    input  logic                             re,
    input  logic [$clog2(PAYLOAD_DEPTH)-1:0] raddr,
    output logic [7:0]                       rdata
);

    logic [PAYLOAD_DEPTH-1:0] valid_reg;
    logic                     hit_reg;
    logic [7:0]               ram_q;

    cfp_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = hit_reg ? ram_q : 8'h00;

endmodule

/* hdl/cfp_rx_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_rx_fsm
// Byte-level frame parser: header, length, payload, checksum, trailer.
// ----------------------------------------------------------------------------
module cfp_rx_fsm
    import cfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data,
    cfp_byte_if.sink                         rx,
    input  logic                             busy,
    output logic                             start,
    output logic                             st_we,
    output logic [$clog2(PAYLOAD_DEPTH)-1:0] st_waddr,
    output logic [7:0]                       st_wdata
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] rcv_sum_reg, rcv_sum_next;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] trailer_reg;
    logic [LEN_W-1:0]  max_len_reg;
    logic              accept;
    logic [8:0]        wr_idx_ext;
    logic [8:0]        wr_idx_mod;

    assign rx.ready = !busy;
    assign accept   = rx.valid && !busy;

    // write position wraps by one subtraction of the store depth (index is below 64)
    assign wr_idx_ext = {3'b000, wr_idx_reg};
    assign wr_idx_mod = (wr_idx_ext >= 9'(PAYLOAD_DEPTH)) ? wr_idx_ext - 9'(PAYLOAD_DEPTH)
                                                          : wr_idx_ext;
    assign st_waddr   = AW'(wr_idx_mod);
    assign st_wdata   = rx.rx_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        wr_idx_next     = wr_idx_reg;
        sum_next        = sum_reg;
        rcv_sum_next    = rcv_sum_reg;
        st_we           = 1'b0;
        start           = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx.rx_byte == header_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (rx.rx_byte <= {2'b00, max_len_reg})
                    begin
                        phase_next      = PH_DATA;
                        bytes_left_next = rx.rx_byte[LEN_W-1:0];
                        wr_idx_next     = '0;
                        sum_next        = rx.rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (bytes_left_reg != '0)
                    begin
                        st_we           = 1'b1;
                        wr_idx_next     = wr_idx_reg + LEN_W'(1);
                        sum_next        = sum_reg + rx.rx_byte;
                        bytes_left_next = bytes_left_reg - LEN_W'(1);
                        if (bytes_left_reg == 6'd1)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SUM:
                begin
                    rcv_sum_next = rx.rx_byte;
                    phase_next   = PH_TAIL;
                end
                PH_TAIL:
                begin
                    phase_next = PH_HUNT;
                    if (rx.rx_byte == trailer_reg && sum_reg == rcv_sum_reg)
                    begin
                        start = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            wr_idx_reg     <= '0;
            sum_reg        <= '0;
            rcv_sum_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            wr_idx_reg     <= wr_idx_next;
            sum_reg        <= sum_next;
            rcv_sum_reg    <= rcv_sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RST;
            trailer_reg <= TRAILER_RST;
            max_len_reg <= MAX_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data;
                CFG_TRAILER: trailer_reg <= cfg_data;
                CFG_MAX_LEN: max_len_reg <= cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    // a frame only completes from the trailer phase with a matching checksum
    a_start_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (phase_reg == PH_TAIL && sum_reg == rcv_sum_reg))
        else $error("frame start outside trailer phase");

    a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |=> (phase_reg == PH_DATA || phase_reg == PH_SUM))
        else $error("payload write outside data phase");

endmodule

/* hdl/cfp_word_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_word_seq
// Word sequencer: reads the store a byte at a time, assembles each 32-bit
// word and converts it to a truncated integer in a shared shift unit.
// ----------------------------------------------------------------------------
module cfp_word_seq
    import cfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 64,
    parameter int WORD_COUNT    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    output logic                             st_re,
    output logic [$clog2(PAYLOAD_DEPTH)-1:0] st_raddr,
    input  logic [7:0]                       st_rdata,
    cfp_result_if.source                     result
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    seq_state_t          state_reg, state_next;
    logic [CHAN_W-1:0]   word_reg, word_next;
    logic [1:0]          byte_reg, byte_next;
    logic [WORD_W-1:0]   asm_reg, asm_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [WORD_W-1:0]   out_raw_reg;
    logic [WHOLE_W-1:0]  out_whole_reg;
    logic                out_last_reg;
    logic                load;
    logic                is_last;
    logic [WHOLE_W-1:0]  whole;

    // binary32 to int32 toward zero, saturating, NaN to 0; low 16 bits only
    function automatic logic [WHOLE_W-1:0] trunc_low16(input logic [WORD_W-1:0] w);
        logic [7:0]         ex;
        logic [22:0]        man;
        logic [WORD_W-1:0]  mag;
        logic [WHOLE_W-1:0] r;
        ex  = w[30:23];
        man = w[22:0];
        mag = '0;
        if (ex == 8'hFF && man != '0)
        begin
            r = '0;
        end
        else if (ex < 8'd127)
        begin
            r = '0;
        end
        else if (ex >= 8'd158)
        begin
            r = w[31] ? 16'h0000 : 16'hFFFF;
        end
        else
        begin
            if (ex >= 8'd150)
            begin
                mag = {8'h00, 1'b1, man} << (ex - 8'd150);
            end
            else
            begin
                mag = {8'h00, 1'b1, man} >> (8'd150 - ex);
            end
            r = w[31] ? 16'(16'h0000 - mag[15:0]) : mag[15:0];
        end
        return r;
    endfunction

    assign is_last  = (word_reg == CHAN_W'(WORD_COUNT - 1));
    assign whole    = trunc_low16(asm_reg);
    assign st_raddr = AW'({word_reg, byte_reg});

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        byte_next  = byte_reg;
        asm_next   = asm_reg;
        st_re      = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    word_next  = '0;
                    byte_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                st_re      = 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                asm_next = {st_rdata, asm_reg[WORD_W-1:8]};
                if (byte_reg == 2'd3)
                begin
                    byte_next  = '0;
                    state_next = ST_CV;
                end
                else
                begin
                    byte_next  = byte_reg + 2'd1;
                    state_next = ST_RD;
                end
            end
            ST_CV:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_next  = word_reg + CHAN_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_reg      <= '0;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            byte_reg      <= byte_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
        if (load)
        begin
            out_chan_reg  <= word_reg;
            out_raw_reg   <= asm_reg;
            out_whole_reg <= whole;
            out_last_reg  <= is_last;
        end
    end

    assign busy               = (state_reg != ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.channel     = out_chan_reg;
    assign result.raw_word    = out_raw_reg;
    assign result.whole_value = out_whole_reg;
    assign result.last        = out_last_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == ST_IDLE))
        else $error("frame start while sequencer busy");

    a_cv_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CV && out_valid_reg && !result.ready) |=> (state_reg == ST_CV))
        else $error("conversion left while output register full");

    a_valid_after_cv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CV))
        else $error("result raised outside conversion step");

endmodule
